// ===== rtl/core/hkv_pkg.sv =====
// Shared types and constants for the hashed key/value store.
`timescale 1ns / 1ps
`default_nettype none

package hkv_pkg;

	// Field widths fixed by the item format.
	localparam int KEY_W = 31;
	localparam int VAL_W = 32;
	localparam int CFG_W = 9;

	// Defaults for the top-level parameters.
	localparam int MAX_BUCKETS_DEF = 256;
	localparam int WAYS_DEF        = 4;

	// Bucket count after reset.
	localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 9'd10;

	// Depth of the queue between the front and back parts.
	localparam int Q_DEPTH = 2;

	typedef enum logic {
		FUNC_ASSIGN = 1'b0,
		FUNC_LOOKUP = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		func_t                   func;
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		status_t                 status;
	} rsp_t;

	// One way of a bucket row in the table memory.
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/hkv_front.sv =====
// Front part: takes requests, holds the bucket count and computes the bucket index.
`timescale 1ns / 1ps
`default_nettype none

module hkv_front #(
	parameter int MAX_BUCKETS = hkv_pkg::MAX_BUCKETS_DEF,
	parameter int BKT_W       = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [hkv_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                     push,
	output logic                          full,
	input  wire hkv_pkg::req_t            req,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output hkv_pkg::req_t                 out_req,
	output logic [BKT_W-1:0]              out_bucket
);
	import hkv_pkg::*;

	localparam int CNT_W = $clog2(KEY_W);

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} fstate_t;

	fstate_t          state_q;
	logic [CFG_W-1:0] bucket_count_q;
	logic [CFG_W-1:0] divisor_q;
	logic [CFG_W-1:0] rem_q;
	logic [KEY_W-1:0] shift_q;
	logic [CNT_W-1:0] cnt_q;
	req_t             req_q;

	logic [CFG_W-1:0] eff_div;
	logic [CFG_W:0]   trial;
	logic [CFG_W:0]   diff;
	logic [CFG_W-1:0] rem_next;
	logic             accept;

	assign accept = push && !full;

	// Clamp the configured bucket count into the usable range.
	always_comb begin
		eff_div = bucket_count_q;
		if (bucket_count_q == '0) begin
			eff_div = CFG_W'(1);
		end else if (int'(bucket_count_q) > MAX_BUCKETS) begin
			eff_div = CFG_W'(MAX_BUCKETS);
		end
	end

	// One restoring division step: bring in the next key bit and subtract if it fits.
	always_comb begin
		trial    = {rem_q, shift_q[KEY_W-1]};
		diff     = trial - {1'b0, divisor_q};
		rem_next = (trial >= {1'b0, divisor_q}) ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
	end

	// Sequencer and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= F_IDLE;
			bucket_count_q <= BUCKET_COUNT_RESET;
			cnt_q          <= '0;
		end else begin
			if (cfg_we) begin
				bucket_count_q <= cfg_data;
			end
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						cnt_q   <= CNT_W'(KEY_W - 1);
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					if (cnt_q == '0) begin
						state_q <= F_PUSH;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				F_PUSH: begin
					if (out_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Request payload and divider datapath.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && accept) begin
			req_q     <= req;
			shift_q   <= req.key;
			divisor_q <= eff_div;
			rem_q     <= '0;
		end else if (state_q == F_DIV) begin
			shift_q <= {shift_q[KEY_W-2:0], 1'b0};
			rem_q   <= rem_next;
		end
	end

	assign full       = (state_q != F_IDLE);
	assign out_valid  = (state_q == F_PUSH);
	assign out_req    = req_q;
	assign out_bucket = BKT_W'(rem_q);

endmodule

`default_nettype wire

// ===== rtl/core/hkv_queue.sv =====
// Short queue of classified requests between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module hkv_queue #(
	parameter int BKT_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire hkv_pkg::req_t     wr_req,
	input  wire logic [BKT_W-1:0]  wr_bucket,
	output logic                   full,
	input  wire logic              rd_en,
	output hkv_pkg::req_t          rd_req,
	output logic [BKT_W-1:0]       rd_bucket,
	output logic                   empty
);
	import hkv_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	req_t             req_q    [Q_DEPTH];
	logic [BKT_W-1:0] bucket_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CNT_W'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			req_q[wr_ptr_q]    <= wr_req;
			bucket_q[wr_ptr_q] <= wr_bucket;
		end
	end

	assign rd_req    = req_q[rd_ptr_q];
	assign rd_bucket = bucket_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== rtl/core/hkv_back.sv =====
// Back part: bucket table memory, read-modify-write of one bucket row and result register.
`timescale 1ns / 1ps
`default_nettype none

module hkv_back #(
	parameter int MAX_BUCKETS = hkv_pkg::MAX_BUCKETS_DEF,
	parameter int WAYS        = hkv_pkg::WAYS_DEF,
	parameter int BKT_W       = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire hkv_pkg::req_t    in_req,
	input  wire logic [BKT_W-1:0] in_bucket,
	output logic                  clearing,
	output logic                  empty,
	input  wire logic             pop,
	output hkv_pkg::rsp_t         rsp
);
	import hkv_pkg::*;

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_EVAL
	} bstate_t;

	bstate_t          state_q;
	logic [BKT_W-1:0] clr_cnt_q;
	logic             out_valid_q;
	rsp_t             out_q;

	req_t             item_q;
	logic [BKT_W-1:0] bucket_q;

	entry_t [WAYS-1:0] mem [MAX_BUCKETS];
	entry_t [WAYS-1:0] rd_row_q;
	entry_t [WAYS-1:0] new_row;
	entry_t [WAYS-1:0] mem_wdata;
	logic [BKT_W-1:0]  mem_waddr;
	logic              mem_we;

	logic             hit;
	logic [WAY_W-1:0] hit_idx;
	logic             free;
	logic [WAY_W-1:0] free_idx;
	logic             write_row;
	rsp_t             rsp_d;
	logic             eval_fire;
	logic             take;

	assign in_ready  = (state_q == B_IDLE);
	assign take      = in_ready && in_valid;
	assign eval_fire = (state_q == B_EVAL) && (!out_valid_q || pop);
	assign clearing  = (state_q == B_CLEAR);

	// Search the bucket row: lowest matching way and lowest free way.
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free     = 1'b0;
		free_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rd_row_q[w].valid && rd_row_q[w].key == item_q.key) begin
				hit     = 1'b1;
				hit_idx = WAY_W'(w);
			end
			if (!rd_row_q[w].valid) begin
				free     = 1'b1;
				free_idx = WAY_W'(w);
			end
		end
	end

	// Build the result and the updated row.
	always_comb begin
		new_row          = rd_row_q;
		write_row        = 1'b0;
		rsp_d.read_value = '0;
		rsp_d.status     = ST_OK;
		if (item_q.func == FUNC_LOOKUP) begin
			if (hit) begin
				rsp_d.read_value = rd_row_q[hit_idx].value;
			end else begin
				rsp_d.status = ST_MISS;
			end
		end else if (hit) begin
			new_row[hit_idx].value = item_q.value;
			write_row              = 1'b1;
		end else if (free) begin
			new_row[free_idx].valid = 1'b1;
			new_row[free_idx].key   = item_q.key;
			new_row[free_idx].value = item_q.value;
			write_row               = 1'b1;
		end else begin
			rsp_d.status = ST_FULL;
		end
	end

	// Memory write port: the clearing sweep after reset, then row updates.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = bucket_q;
		mem_wdata = new_row;
		if (state_q == B_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else if (eval_fire && write_row) begin
			mem_we = 1'b1;
		end
	end

	// Bucket table memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (take) begin
			rd_row_q <= mem[in_bucket];
		end
	end

	// Request payload held while its row is evaluated.
	always_ff @(posedge clk) begin
		if (take) begin
			item_q   <= in_req;
			bucket_q <= in_bucket;
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (eval_fire) begin
				out_q       <= rsp_d;
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					if (clr_cnt_q == BKT_W'(MAX_BUCKETS - 1)) begin
						state_q <= B_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + BKT_W'(1);
					end
				end
				B_IDLE: begin
					if (in_valid) begin
						state_q <= B_EVAL;
					end
				end
				B_EVAL: begin
					if (eval_fire) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign empty = !out_valid_q;
	assign rsp   = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/hashed_key_value_store_top.sv =====
// Top level of the hashed key/value store: front part, request queue and back part.
`timescale 1ns / 1ps
`default_nettype none

// Hashed key/value store with WAYS entries in each of MAX_BUCKETS buckets.
// Input channel: a request (func, key, value) is taken when push is high and full is low.
// An assign stores value under key; a lookup returns the stored value or a not-found status.
// Result channel: the oldest result is on rsp while empty is low; pop takes it.
// Every request gives exactly one result, in request order.
// The bucket is key modulo bucket_count, written through cfg_we/cfg_data by the user only
// while idle; the block does not enforce this. A count of zero acts as one and a count above
// MAX_BUCKETS acts as MAX_BUCKETS. The front part takes no new request until it has handed
// the last one on: its bit-serial remainder unit takes one key bit per cycle over all KEY_W
// key bits, then the request waits in the handoff state until the queue has room.
// The back part registers a bucket row, then writes it back updated as it stores the result.
// After reset the back part clears the table, one bucket row per cycle, over all MAX_BUCKETS
// rows; full stays high during that time. Configuration writes are taken throughout.
// When pop stays low, the result register holds, then the queue fills, then full rises.
module hashed_key_value_store_top #(
	parameter int MAX_BUCKETS = hkv_pkg::MAX_BUCKETS_DEF,
	parameter int WAYS        = hkv_pkg::WAYS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [hkv_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      push,
	output logic                           full,
	input  wire hkv_pkg::req_t             req,
	output logic                           empty,
	input  wire logic                      pop,
	output hkv_pkg::rsp_t                  rsp
);
	import hkv_pkg::*;

	localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

	logic             front_full;
	logic             front_push;
	logic             clearing;
	logic             f_valid;
	logic             q_full;
	req_t             f_req;
	logic [BKT_W-1:0] f_bucket;
	logic             q_empty;
	logic             b_ready;
	req_t             q_req;
	logic [BKT_W-1:0] q_bucket;

	// No requests are taken while the table is being cleared.
	assign front_push = push && !clearing;
	assign full       = front_full || clearing;

	hkv_front #(
		.MAX_BUCKETS(MAX_BUCKETS),
		.BKT_W      (BKT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.push      (front_push),
		.full      (front_full),
		.req       (req),
		.out_valid (f_valid),
		.out_ready (!q_full),
		.out_req   (f_req),
		.out_bucket(f_bucket)
	);

	hkv_queue #(
		.BKT_W(BKT_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (f_valid),
		.wr_req   (f_req),
		.wr_bucket(f_bucket),
		.full     (q_full),
		.rd_en    (b_ready),
		.rd_req   (q_req),
		.rd_bucket(q_bucket),
		.empty    (q_empty)
	);

	hkv_back #(
		.MAX_BUCKETS(MAX_BUCKETS),
		.WAYS       (WAYS),
		.BKT_W      (BKT_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!q_empty),
		.in_ready (b_ready),
		.in_req   (q_req),
		.in_bucket(q_bucket),
		.clearing (clearing),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the hashed key/value store top level.
`timescale 1ns / 1ps

module tb;
	import hkv_pkg::*;

	localparam int NUM_BUCKETS = MAX_BUCKETS_DEF;
	localparam int NUM_WAYS    = WAYS_DEF;
	localparam int NUM_ENTRIES = NUM_BUCKETS * NUM_WAYS;
	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 113;
	localparam int STALL_LIMIT     = 5000;
	localparam int RX_HOLD_CYCLES  = 400;
	localparam int KEY_POOL_SIZE   = 24;
	localparam int DIRECTED_ROWS   = 20;

	typedef struct {
		func_t            func;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		bit               fixed;
		logic [VAL_W-1:0] want_value;
		status_t          want_status;
	} directed_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_data;
	logic             push;
	logic             full;
	req_t             req;
	logic             empty;
	logic             pop;
	rsp_t             rsp;

	// Predicted copy of the table and the bucket count register.
	logic [KEY_W-1:0] shadow_key [NUM_ENTRIES];
	logic [VAL_W-1:0] shadow_val [NUM_ENTRIES];
	bit               shadow_valid [NUM_ENTRIES];
	logic [CFG_W-1:0] shadow_count;

	rsp_t             pending_rsp [$];
	logic [KEY_W-1:0] live_keys [$];
	int               mismatch_count;
	int               results_seen;
	bit               tx_steady;

	// Bucket count 10 after reset; the rows fill bucket 0 and touch buckets 7, 2 and 5.
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{FUNC_LOOKUP, 31'd0,          32'h0000_0000, 1'b1, 32'h0000_0000, ST_MISS},
		'{FUNC_LOOKUP, KEY_MAX,        32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_MISS},
		'{FUNC_ASSIGN, 31'd0,          32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
		'{FUNC_LOOKUP, 31'd0,          32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK},
		'{FUNC_ASSIGN, KEY_MAX,        32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
		'{FUNC_LOOKUP, KEY_MAX,        32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK},
		'{FUNC_ASSIGN, 31'd0,          32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
		'{FUNC_LOOKUP, 31'd0,          32'hDEAD_BEEF, 1'b1, 32'hFFFF_FFFF, ST_OK},
		'{FUNC_ASSIGN, 31'd10,         32'd1,         1'b1, 32'h0000_0000, ST_OK},
		'{FUNC_ASSIGN, 31'd20,         32'd2,         1'b1, 32'h0000_0000, ST_OK},
		'{FUNC_ASSIGN, 31'd30,         32'd3,         1'b1, 32'h0000_0000, ST_OK},
		'{FUNC_ASSIGN, 31'd40,         32'd4,         1'b1, 32'h0000_0000, ST_FULL},
		'{FUNC_ASSIGN, 31'd2147483640, 32'd5,         1'b1, 32'h0000_0000, ST_FULL},
		'{FUNC_LOOKUP, 31'd40,         32'h0000_0000, 1'b1, 32'h0000_0000, ST_MISS},
		'{FUNC_ASSIGN, 31'd20,         32'd22,        1'b1, 32'h0000_0000, ST_OK},
		'{FUNC_LOOKUP, 31'd20,         32'h0000_0000, 1'b1, 32'd22,        ST_OK},
		'{FUNC_LOOKUP, 31'd30,         32'h0000_0000, 1'b1, 32'd3,         ST_OK},
		'{FUNC_ASSIGN, 31'h2AAA_AAAA,  32'h5555_5555, 1'b0, 32'h0000_0000, ST_OK},
		'{FUNC_LOOKUP, 31'h2AAA_AAAA,  32'hAAAA_AAAA, 1'b0, 32'h0000_0000, ST_OK},
		'{FUNC_LOOKUP, 31'h5555_5555,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK}
	};

	// Bucket count used for every phase after the directed part; zero marks a random pick.
	int unsigned count_plan [PHASES] = '{256, 1, 0, 511, 3, 7, 255, 0, 0, 2};

	hashed_key_value_store_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.push    (push),
		.full    (full),
		.req     (req),
		.empty   (empty),
		.pop     (pop),
		.rsp     (rsp)
	);

	always #5 clk = ~clk;

	// Divisor of the key hash as the block applies it.
	function automatic int unsigned effective_buckets();
		int unsigned nb;
		nb = shadow_count;
		if (nb == 0) begin
			nb = 1;
		end
		if (nb > NUM_BUCKETS) begin
			nb = NUM_BUCKETS;
		end
		return nb;
	endfunction

	// Applies one request to the shadow table and returns the result it should give.
	function automatic rsp_t predict_table_op(req_t r);
		int unsigned base;
		int          hit;
		int          free_way;
		rsp_t        res;
		base = (r.key % effective_buckets()) * NUM_WAYS;
		hit = -1;
		free_way = -1;
		res.read_value = '0;
		res.status = ST_OK;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (hit < 0 && shadow_valid[base + w] && shadow_key[base + w] == r.key) begin
				hit = base + w;
			end
			if (free_way < 0 && !shadow_valid[base + w]) begin
				free_way = base + w;
			end
		end
		if (r.func == FUNC_LOOKUP) begin
			if (hit >= 0) begin
				res.read_value = shadow_val[hit];
			end else begin
				res.status = ST_MISS;
			end
		end else if (hit >= 0) begin
			shadow_val[hit] = r.value;
		end else if (free_way >= 0) begin
			shadow_valid[free_way] = 1'b1;
			shadow_key[free_way] = r.key;
			shadow_val[free_way] = r.value;
		end else begin
			res.status = ST_FULL;
		end
		return res;
	endfunction

	// Picks a key that was used before, or a new one that mostly lands in a few buckets.
	function automatic logic [KEY_W-1:0] pick_key(bit reuse);
		int unsigned       nb;
		int unsigned       b;
		int unsigned       mode;
		longint unsigned   m_max;
		longint unsigned   m;
		longint unsigned   k;
		nb = effective_buckets();
		if (reuse && live_keys.size() != 0) begin
			return live_keys[$urandom_range(live_keys.size() - 1)];
		end
		mode = $urandom_range(99);
		if (mode < 15) begin
			return KEY_W'($urandom);
		end
		if (mode < 20) begin
			if ($urandom_range(1) == 1) begin
				return KEY_MAX;
			end
			return '0;
		end
		b = $urandom_range(((nb > 4) ? 4 : nb) - 1);
		m_max = (longint'(KEY_MAX) - b) / nb;
		if ($urandom_range(1) == 1) begin
			m = $urandom_range(7);
		end else begin
			m = longint'($urandom) % (m_max + 1);
		end
		k = b + m * nb;
		return k[KEY_W-1:0];
	endfunction

	// Builds one random request and remembers new keys for later hits.
	function automatic req_t random_request();
		req_t        r;
		int unsigned pick;
		r.func = ($urandom_range(1) == 1) ? FUNC_LOOKUP : FUNC_ASSIGN;
		if (r.func == FUNC_LOOKUP) begin
			r.key = pick_key($urandom_range(99) < 75);
		end else begin
			r.key = pick_key($urandom_range(1) == 1);
			if (live_keys.size() < KEY_POOL_SIZE) begin
				live_keys.push_back(r.key);
			end else begin
				live_keys[$urandom_range(KEY_POOL_SIZE - 1)] = r.key;
			end
		end
		pick = $urandom_range(99);
		case (pick % 4)
			0: r.value = 32'h0000_0000;
			1: r.value = 32'h7FFF_FFFF;
			2: r.value = 32'h8000_0000;
			default: r.value = 32'hFFFF_FFFF;
		endcase
		if (pick >= 10) begin
			r.value = $urandom;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Offers one request, idling at random first unless tx_steady; waits until it is taken.
	task automatic offer_request(req_t r, bit fixed, rsp_t want);
		rsp_t predicted;
		while (!tx_steady && $urandom_range(99) < 32) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req <= r;
		do begin
			@(posedge clk);
		end while (full);
		predicted = predict_table_op(r);
		pending_rsp.push_back(fixed ? want : predicted);
	endtask

	task automatic write_bucket_count(logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		shadow_count = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain_results();
		while (pending_rsp.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Result side: checks every result taken, idles at random, and holds off once for long.
	initial begin
		int   hold_left;
		bit   hold_done;
		rsp_t want;
		pop = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (pending_rsp.size() == 0) begin
					report_mismatch("unexpected result", rsp.read_value, '0);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.read_value !== want.read_value) begin
						report_mismatch("read_value", rsp.read_value, want.read_value);
					end
					if (rsp.status !== want.status) begin
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					end
				end
				results_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (results_seen == 150 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = RX_HOLD_CYCLES;
				pop <= 1'b0;
			end else begin
				pop <= (results_seen >= 450 && results_seen < 650) || $urandom_range(99) >= 32;
			end
		end
	end

	// Ends the run when nothing moves on either side for too long.
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles == STALL_LIMIT) begin
				$display("hashed_key_value_store_top test failed");
				$finish;
			end
		end
	end

	// Request side: directed rows at the reset bucket count, then random phases.
	initial begin
		req_t        r;
		rsp_t        want;
		int unsigned nb;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		push = 1'b0;
		req = '0;
		shadow_count = BUCKET_COUNT_RESET;
		mismatch_count = 0;
		results_seen = 0;
		tx_steady = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			r.func = directed_rows[i].func;
			r.key = directed_rows[i].key;
			r.value = directed_rows[i].value;
			want.read_value = directed_rows[i].want_value;
			want.status = directed_rows[i].want_status;
			offer_request(r, directed_rows[i].fixed, want);
		end

		for (int p = 0; p < PHASES; p++) begin
			// The sender pauses here until every result of the last phase is back.
			push <= 1'b0;
			drain_results();
			nb = count_plan[p];
			if (nb == 0) begin
				nb = $urandom_range(2, 300);
			end
			write_bucket_count(CFG_W'(nb));
			tx_steady = (p == 4);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				offer_request(random_request(), 1'b0, want);
			end
		end
		push <= 1'b0;
		drain_results();
		repeat (50) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("hashed_key_value_store_top test passed");
		end else begin
			$display("hashed_key_value_store_top test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/hkv_pkg.sv
rtl/core/hkv_front.sv
rtl/core/hkv_queue.sv
rtl/core/hkv_back.sv
rtl/core/hashed_key_value_store_top.sv
sim/tb.sv
